@@ src/ntdm_pkg.sv @@
package ntdm_pkg;

  localparam int FIELD_W    = 16;  // width of one coordinate field on the bus
  localparam int SUM_W      = 48;  // saturating accumulator
  localparam int DIST_W     = 24;  // floor square root of the accumulator
  localparam int IDX_W      = 8;   // template index fields
  localparam int ROOT_STEPS = DIST_W;
  localparam int STEP_W     = $clog2(ROOT_STEPS);

  localparam logic [SUM_W-1:0]  SUM_MAX  = '1;
  localparam logic [DIST_W-1:0] DIST_MAX = '1;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_ACC  = 4'b0010,
    S_ROOT = 4'b0100,
    S_DONE = 4'b1000
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic capture;     // take the request into the square registers
    logic accum;       // add the squares to the running sum
    logic root_start;  // move the sum into the root unit, clear the sum
    logic root_step;   // one digit of the square root
    logic finish;      // compare, load the result register, advance the set
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic last_point;  // captured request closes a template
    logic root_done;   // the current step is the last digit
    logic out_free;    // result register can take a new result this cycle
  } stat_t;

endpackage

@@ src/ntdm_ctrl.sv @@
module ntdm_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           s_tvalid,
  output logic           s_tready,
  input  ntdm_pkg::stat_t stat,
  output ntdm_pkg::cmd_t  cmd
);
  import ntdm_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign s_tready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          cmd.capture = 1'b1;
          state_next  = S_ACC;
        end
      end
      S_ACC: begin
        cmd.accum = 1'b1;
        if (stat.last_point) begin
          cmd.root_start = 1'b1;
          state_next     = S_ROOT;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_ROOT: begin
        cmd.root_step = 1'b1;
        if (stat.root_done) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  a_finish_free: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |-> stat.out_free)
    else $error("result loaded while output register is occupied");

  a_accept_acc: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> cmd.accum)
    else $error("accepted request not accumulated next cycle");

  a_root_after_acc: assert property (@(posedge clk) disable iff (rst)
    cmd.root_start |=> (cmd.root_step && !s_tready))
    else $error("root unit not stepping after start");

endmodule

@@ src/ntdm_dp.sv @@
module ntdm_dp #(
  parameter int MAX_TEMPLATES = 256,
  parameter int COORD_BITS    = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  ntdm_pkg::cmd_t                       cmd,
  output ntdm_pkg::stat_t                      stat,
  input  logic [ntdm_pkg::FIELD_W-1:0]         known_x,
  input  logic [ntdm_pkg::FIELD_W-1:0]         known_y,
  input  logic [ntdm_pkg::FIELD_W-1:0]         unknown_x,
  input  logic [ntdm_pkg::FIELD_W-1:0]         unknown_y,
  input  logic                                 last_point,
  input  logic                                 last_template,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [ntdm_pkg::IDX_W-1:0]           template_index,
  output logic [ntdm_pkg::DIST_W-1:0]          distance,
  output logic [ntdm_pkg::IDX_W-1:0]           best_index,
  output logic [ntdm_pkg::DIST_W-1:0]          best_distance,
  output logic                                 set_done
);
  import ntdm_pkg::*;

  localparam int EXT_W = (COORD_BITS > FIELD_W) ? COORD_BITS : FIELD_W;
  localparam int MAG_W = COORD_BITS + 1;
  localparam int SQ_W  = 2 * MAG_W;
  localparam int ADD_W = SQ_W + 1;
  localparam int ACC_W = ((ADD_W > SUM_W) ? ADD_W : SUM_W) + 1;
  localparam int CNT_W = (MAX_TEMPLATES > 1) ? $clog2(MAX_TEMPLATES) : 1;
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(MAX_TEMPLATES - 1);
  localparam int REM_W = DIST_W + 1;

  // raw field read as a COORD_BITS-bit two's-complement value
  function automatic logic signed [COORD_BITS-1:0] coord(input logic [FIELD_W-1:0] raw);
    logic [EXT_W-1:0] e;
    e = EXT_W'(raw);
    return $signed(e[COORD_BITS-1:0]);
  endfunction

  function automatic logic [MAG_W-1:0] abs_diff(input logic [FIELD_W-1:0] a,
                                                input logic [FIELD_W-1:0] b);
    logic signed [MAG_W-1:0] d;
    d = MAG_W'(coord(a)) - MAG_W'(coord(b));
    return d[MAG_W-1] ? MAG_W'(-d) : MAG_W'(d);
  endfunction

  // ---------------- capture: one square per axis ----------------
  logic [MAG_W-1:0] mag_x, mag_y;
  logic [SQ_W-1:0]  sq_x, sq_y;
  logic             cap_last, cap_done;

  assign mag_x = abs_diff(known_x, unknown_x);
  assign mag_y = abs_diff(known_y, unknown_y);

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      sq_x     <= SQ_W'(mag_x) * SQ_W'(mag_x);
      sq_y     <= SQ_W'(mag_y) * SQ_W'(mag_y);
      cap_last <= last_point;
      cap_done <= last_template;
    end
  end

  // ---------------- saturating accumulator ----------------
  logic [SUM_W-1:0] sum, sum_next;
  logic [ACC_W-1:0] sum_wide;

  assign sum_wide = ACC_W'(sum) + ACC_W'(sq_x) + ACC_W'(sq_y);
  assign sum_next = (sum_wide > ACC_W'(SUM_MAX)) ? SUM_MAX : SUM_W'(sum_wide);

  // ---------------- digit-by-digit square root ----------------
  logic [SUM_W-1:0]  rt_val;
  logic [REM_W-1:0]  rt_rem;
  logic [DIST_W-1:0] rt_root;
  logic [STEP_W-1:0] rt_cnt;
  logic [REM_W+1:0]  rem_sh, trial;
  logic              take;

  assign rem_sh = {rt_rem, rt_val[SUM_W-1 -: 2]};
  assign trial  = (REM_W + 2)'({rt_root, 2'b01});
  assign take   = (rem_sh >= trial);

  always_ff @(posedge clk) begin
    if (cmd.root_start) begin
      rt_val  <= sum_next;
      rt_rem  <= '0;
      rt_root <= '0;
      rt_cnt  <= '0;
    end else if (cmd.root_step) begin
      rt_val  <= {rt_val[SUM_W-3:0], 2'b00};
      rt_rem  <= take ? REM_W'(rem_sh - trial) : REM_W'(rem_sh);
      rt_root <= {rt_root[DIST_W-2:0], take};
      rt_cnt  <= rt_cnt + STEP_W'(1);
    end
  end

  // ---------------- running minimum and template count ----------------
  logic [CNT_W-1:0]  count;
  logic [DIST_W-1:0] min_dist, new_min;
  logic [IDX_W-1:0]  min_idx, new_idx;
  logic              better;

  assign better  = (rt_root < min_dist);
  assign new_min = better ? rt_root : min_dist;
  assign new_idx = better ? IDX_W'(count) : min_idx;

  always_ff @(posedge clk) begin
    if (rst) begin
      sum      <= '0;
      count    <= '0;
      min_dist <= DIST_MAX;
      min_idx  <= '0;
    end else begin
      if (cmd.accum) begin
        sum <= cmd.root_start ? '0 : sum_next;
      end
      if (cmd.finish) begin
        if (cap_done) begin
          count    <= '0;
          min_dist <= DIST_MAX;
          min_idx  <= '0;
        end else begin
          count    <= (count == CNT_LAST) ? '0 : count + CNT_W'(1);
          min_dist <= new_min;
          min_idx  <= new_idx;
        end
      end
    end
  end

  // ---------------- result register ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      template_index <= IDX_W'(count);
      distance       <= rt_root;
      best_index     <= new_idx;
      best_distance  <= new_min;
      set_done       <= cap_done;
    end
  end

  assign stat.last_point = cap_last;
  assign stat.root_done  = (rt_cnt == STEP_W'(ROOT_STEPS - 1));
  assign stat.out_free   = !out_valid || out_ready;

  a_best_le_dist: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (best_distance <= distance))
    else $error("best distance above the distance it was compared with");

  a_finish_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |=> out_valid)
    else $error("result register not valid after load");

  a_sum_cleared: assert property (@(posedge clk) disable iff (rst)
    cmd.root_start |=> (sum == '0 && rt_cnt == '0))
    else $error("sum or root counter not cleared at root start");

endmodule

@@ src/nearest_template_distance_match.sv @@
// nearest_template_distance_match
//
// Input stream (s_*): one request per point pair, template point and the
// matching point of the unknown grid. s_tlast marks the last point of a
// template, s_tuser marks that this template is the last of the set (only
// looked at together with s_tlast).
// Output stream (m_*): one result per finished template: its index, its
// distance (floor sqrt of the saturating sum of squared differences), the
// best index/distance so far (first of equal minima wins). m_tlast marks the
// result that closes the set; the block then starts a fresh set.
//
// A point is squared, then accumulated, and no new request is taken before
// both steps are done. The last point of a template then runs through the
// bit-serial square root (one result bit per cycle), which forms the distance,
// and then the result register is loaded.
// The result register decouples the sides: new requests are taken while a
// result waits. If a second result is ready before the first is taken, the
// block holds in its final state and s_tready stays low until m_tready.
// Reset (rst, synchronous) clears the sum, template count and minimum.
module nearest_template_distance_match #(
  parameter int MAX_TEMPLATES = 256,
  parameter int COORD_BITS    = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // known_x, known_y, unknown_x, unknown_y (16 bits each)
  input  logic        s_tlast,   // last_point
  input  logic        s_tuser,   // last_template
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata,   // template_index[8], distance[24], best_index[8],
                                 // best_distance[24]
  output logic        m_tlast    // set_done
);
  import ntdm_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  logic [IDX_W-1:0]  template_index, best_index;
  logic [DIST_W-1:0] distance, best_distance;

  ntdm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  ntdm_dp #(
    .MAX_TEMPLATES (MAX_TEMPLATES),
    .COORD_BITS    (COORD_BITS)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .stat           (stat),
    .known_x        (s_tdata[15:0]),
    .known_y        (s_tdata[31:16]),
    .unknown_x      (s_tdata[47:32]),
    .unknown_y      (s_tdata[63:48]),
    .last_point     (s_tlast),
    .last_template  (s_tuser),
    .out_valid      (m_tvalid),
    .out_ready      (m_tready),
    .template_index (template_index),
    .distance       (distance),
    .best_index     (best_index),
    .best_distance  (best_distance),
    .set_done       (m_tlast)
  );

  assign m_tdata = {best_distance, best_index, distance, template_index};

endmodule

@@ bench/template_match_checker.sv @@
`timescale 1ns / 1ps

// Watches both streams, predicts each template result and compares it.
module template_match_checker #(
  parameter int MAX_TEMPLATES = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [63:0] s_tdata,
  input  logic        s_tlast,
  input  logic        s_tuser,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [63:0] m_tdata,
  input  logic        m_tlast,
  output int          mismatches,
  output int          pending,
  output int          results_checked,
  output int          sets_closed
);
  import ntdm_pkg::*;

  typedef struct packed {
    logic [IDX_W-1:0]  tmpl_idx;
    logic [DIST_W-1:0] dist_val;
    logic [IDX_W-1:0]  best_idx;
    logic [DIST_W-1:0] best_dist;
    logic              set_done;
  } match_rec_t;

  match_rec_t        match_q[$];
  logic [SUM_W-1:0]  sq_sum;
  int                tmpl_count;
  logic [DIST_W-1:0] min_dist;
  logic [IDX_W-1:0]  min_idx;

  initial begin
    mismatches      = 0;
    pending         = 0;
    results_checked = 0;
    sets_closed     = 0;
  end

  function automatic logic [63:0] diff_square(logic [FIELD_W-1:0] a, logic [FIELD_W-1:0] b);
    logic signed [63:0] d;
    d = $signed({{(64-FIELD_W){a[FIELD_W-1]}}, a}) - $signed({{(64-FIELD_W){b[FIELD_W-1]}}, b});
    return d * d;
  endfunction

  // bit-by-bit floor square root
  function automatic logic [DIST_W-1:0] root_floor(logic [SUM_W-1:0] v);
    logic [DIST_W-1:0] r;
    logic [DIST_W-1:0] trial;
    logic [SUM_W-1:0]  sq;
    r = '0;
    for (int b = DIST_W - 1; b >= 0; b--) begin
      trial = r | (DIST_W'(1) << b);
      sq = SUM_W'(trial) * SUM_W'(trial);
      if (sq <= v) r = trial;
    end
    return r;
  endfunction

  task automatic compare_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
    end
  endtask

  task automatic start_set();
    sq_sum     = '0;
    tmpl_count = 0;
    min_dist   = DIST_MAX;
    min_idx    = '0;
  endtask

  always @(posedge clk) begin : watch
    logic [63:0]       total;
    logic [DIST_W-1:0] root;
    match_rec_t        rec;
    if (rst) begin
      start_set();
      match_q.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        if (match_q.size() == 0) begin
          mismatches++;
          $display("%0t: result expected none actual tdata %h tlast %b",
                   $time, m_tdata, m_tlast);
        end else begin
          rec = match_q.pop_front();
          compare_field("template_index", rec.tmpl_idx, m_tdata[7:0]);
          compare_field("distance", rec.dist_val, m_tdata[31:8]);
          compare_field("best_index", rec.best_idx, m_tdata[39:32]);
          compare_field("best_distance", rec.best_dist, m_tdata[63:40]);
          compare_field("set_done", rec.set_done, m_tlast);
          results_checked++;
          if (rec.set_done) sets_closed++;
        end
      end
      if (s_tvalid && s_tready) begin
        total = 64'(sq_sum) + diff_square(s_tdata[15:0], s_tdata[47:32])
                + diff_square(s_tdata[31:16], s_tdata[63:48]);
        sq_sum = (total > 64'(SUM_MAX)) ? SUM_MAX : total[SUM_W-1:0];
        if (s_tlast) begin
          root = root_floor(sq_sum);
          // strict less-than: first of equal minima keeps its index
          if (root < min_dist) begin
            min_dist = root;
            min_idx  = IDX_W'(tmpl_count);
          end
          rec.tmpl_idx  = IDX_W'(tmpl_count);
          rec.dist_val  = root;
          rec.best_idx  = min_idx;
          rec.best_dist = min_dist;
          rec.set_done  = s_tuser;
          match_q.push_back(rec);
          if (s_tuser) begin
            start_set();
          end else begin
            sq_sum     = '0;
            tmpl_count = (tmpl_count + 1) % MAX_TEMPLATES;
          end
        end
      end
    end
    pending = match_q.size();
  end

endmodule

@@ bench/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
  import ntdm_pkg::*;

  localparam int IDLE_LIMIT  = 4000;   // cycles with no handshake on either side
  localparam int LONG_POINTS = 40;     // max-diff points in one template
  localparam int WRAP_TMPLS  = 260;    // one set longer than the template count
  localparam int RAND_POINTS = 1100;

  typedef enum logic [1:0] {
    RDY_ALWAYS,
    RDY_COIN,
    RDY_SPARSE,
    RDY_PERIODIC
  } ready_mode_t;

  typedef enum logic [1:0] {
    PT_RANDOM,
    PT_NEAR,
    PT_EXACT,
    PT_EXTREME
  } point_style_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [63:0] s_tdata;   // known_x, known_y, unknown_x, unknown_y
  logic        s_tlast;   // last_point
  logic        s_tuser;   // last_template
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [63:0] m_tdata;   // template_index, distance, best_index, best_distance
  logic        m_tlast;   // set_done

  int mismatches;
  int pending;
  int results_checked;
  int sets_closed;

  int points_sent = 0;
  int tmpls_sent  = 0;
  int burst_left  = 0;
  int idle_cycles = 0;

  ready_mode_t ready_mode = RDY_ALWAYS;
  int          ready_left = 0;

  nearest_template_distance_match DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  template_match_checker CHK (
    .clk             (clk),
    .rst             (rst),
    .s_tvalid        (s_tvalid),
    .s_tready        (s_tready),
    .s_tdata         (s_tdata),
    .s_tlast         (s_tlast),
    .s_tuser         (s_tuser),
    .m_tvalid        (m_tvalid),
    .m_tready        (m_tready),
    .m_tdata         (m_tdata),
    .m_tlast         (m_tlast),
    .mismatches      (mismatches),
    .pending         (pending),
    .results_checked (results_checked),
    .sets_closed     (sets_closed)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Receiver: switches now and then between randomly chosen stall patterns.
  always @(negedge clk) begin
    if (ready_left == 0) begin
      ready_mode <= ready_mode_t'($urandom_range(0, 3));
      ready_left <= $urandom_range(20, 200);
    end else begin
      ready_left <= ready_left - 1;
    end
    case (ready_mode)
      RDY_ALWAYS:   m_tready <= 1'b1;
      RDY_COIN:     m_tready <= ($urandom_range(0, 1) == 1);
      RDY_SPARSE:   m_tready <= ($urandom_range(0, 3) == 0);
      default:      m_tready <= (ready_left[3:0] < 4'd5);
    endcase
  end

  // Watchdog: a long stretch with no handshake means the block hung.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles == IDLE_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles, %0d results outstanding",
               IDLE_LIMIT, pending);
      $display("nearest_template_distance_match: mismatch");
      $finish;
    end
  end

  function automatic logic [15:0] pick_extreme();
    case ($urandom_range(0, 3))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2:       return 16'h0000;
      default: return 16'hFFFF;
    endcase
  endfunction

  // packed request data: {unknown_y, unknown_x, known_y, known_x}
  function automatic logic [63:0] make_point(point_style_t style);
    logic [15:0] kx;
    logic [15:0] ky;
    logic [15:0] ux;
    logic [15:0] uy;
    kx = $urandom;
    ky = $urandom;
    ux = $urandom;
    uy = $urandom;
    case (style)
      PT_NEAR: begin
        // small offsets keep distances low, so ties and new minima show up
        ux = kx + 16'($urandom_range(0, 16)) - 16'd8;
        uy = ky + 16'($urandom_range(0, 16)) - 16'd8;
      end
      PT_EXACT: begin
        ux = kx;
        uy = ky;
      end
      PT_EXTREME: begin
        kx = pick_extreme();
        ky = pick_extreme();
        ux = pick_extreme();
        uy = pick_extreme();
      end
      default: ;
    endcase
    return {uy, ux, ky, kx};
  endfunction

  // Holds one request on the bus until it is taken.
  task automatic send_point(logic [63:0] data, logic lp, logic lt);
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata  <= data;
    s_tlast  <= lp;
    s_tuser  <= lt;
    do @(posedge clk); while (!s_tready);
    points_sent++;
    if (lp) tmpls_sent++;
  endtask

  task automatic idle(int n);
    if (n > 0) begin
      @(negedge clk);
      s_tvalid <= 1'b0;
      repeat (n - 1) @(negedge clk);
    end
  endtask

  // Sender in bursts; now and then a long burst with no gaps at all.
  task automatic push_point(logic [63:0] data, logic lp, logic lt);
    if (burst_left == 0) begin
      idle($urandom_range(1, 12));
      burst_left = ($urandom_range(0, 7) == 0) ? 300 : $urandom_range(1, 40);
    end
    burst_left--;
    send_point(data, lp, lt);
  endtask

  // Holds off the sender until every outstanding result has been taken.
  task automatic wait_results();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  // One set of templates; non-final points sometimes carry a stray
  // last_template flag, which the block must ignore.
  task automatic run_set(int n_tmpls, int max_len);
    point_style_t style;
    int           len;
    logic         lt;
    for (int t = 0; t < n_tmpls; t++) begin
      style = point_style_t'($urandom_range(0, 3));
      len   = ($urandom_range(0, 9) == 0) ? $urandom_range(1, max_len) : $urandom_range(1, 6);
      for (int p = 0; p < len; p++) begin
        if (p == len - 1) lt = (t == n_tmpls - 1);
        else lt = ($urandom_range(0, 7) == 0);
        push_point(make_point(style), p == len - 1, lt);
      end
    end
  endtask

  initial begin
    int base;
    int set_no;
    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    s_tlast  = 1'b0;
    s_tuser  = 1'b0;
    repeat (5) @(negedge clk);
    rst <= 1'b0;

    // Set of four: zero distance, extreme two-point template with a stray
    // last_template flag on its first point, a tie at zero (first stays best),
    // then a small distance that closes the set.
    push_point(64'h0, 1'b1, 1'b0);
    push_point({16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF}, 1'b0, 1'b1);
    push_point({16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF}, 1'b1, 1'b0);
    push_point({16'h8000, 16'h8000, 16'h8000, 16'h8000}, 1'b1, 1'b0);
    push_point({16'hFFFE, 16'h1230, 16'hFFFB, 16'h1234}, 1'b1, 1'b1);

    // Fresh set: the minimum moves down twice, to index 2 at the end.
    push_point({16'hFFFF, 16'h0001, 16'h0001, 16'hFFFF}, 1'b1, 1'b0);
    push_point({16'h0004, 16'h0003, 16'h0000, 16'h0000}, 1'b1, 1'b0);
    push_point({16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF}, 1'b1, 1'b1);

    // One-template set.
    push_point({16'h0000, 16'h0000, 16'h0000, 16'h000A}, 1'b1, 1'b1);

    // Long first template of maximum differences: the sum runs far past
    // 32 bits and the root grows to 20 of its 24 bits. Sent without gaps.
    for (int i = 0; i < LONG_POINTS; i++) begin
      send_point({16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF}, i == LONG_POINTS - 1, 1'b0);
    end
    push_point({16'h0003, 16'h0002, 16'h0001, 16'h0001}, 1'b1, 1'b0);
    push_point({16'h0000, 16'h0000, 16'h0000, 16'h0000}, 1'b0, 1'b0);
    push_point({16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF}, 1'b1, 1'b1);
    wait_results();

    // Random sets; one long set wraps the template index, and every few sets
    // the sender waits for the result side to run dry.
    base   = points_sent;
    set_no = 0;
    while (points_sent - base < RAND_POINTS) begin
      if (set_no == 4) begin
        for (int t = 0; t < WRAP_TMPLS; t++) begin
          push_point(make_point(point_style_t'($urandom_range(0, 3))),
                     1'b1, t == WRAP_TMPLS - 1);
        end
      end else if ($urandom_range(0, 4) == 0) begin
        run_set($urandom_range(9, 20), 40);
      end else begin
        run_set($urandom_range(1, 8), 60);
      end
      set_no++;
      if (set_no % 6 == 3) wait_results();
    end

    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (40) @(posedge clk);

    $display("covered %0d point requests over %0d templates; %0d results checked, %0d sets closed",
             points_sent, tmpls_sent, results_checked, sets_closed);
    $display("included a %0d-point max-difference template and a %0d-template set past the wrap",
             LONG_POINTS, WRAP_TMPLS);
    if (mismatches == 0) begin
      $display("nearest_template_distance_match: match");
    end else begin
      $display("nearest_template_distance_match: mismatch");
    end
    $finish;
  end

endmodule
